/* rtl/core/pfre_pkg.sv */
// Shared types and codes for the palette fade and rotate engine.
// Used by pfre_ctrl, pfre_datapath and palette_fade_rotate_engine.
package pfre_pkg;

    localparam int FIELD_BITS = 8;

    // Command codes carried in the request
    localparam logic [2:0] CMD_WR_WORK  = 3'd0;
    localparam logic [2:0] CMD_WR_TGT   = 3'd1;
    localparam logic [2:0] CMD_RD_WORK  = 3'd2;
    localparam logic [2:0] CMD_DIM      = 3'd3;
    localparam logic [2:0] CMD_BRIGHTEN = 3'd4;
    localparam logic [2:0] CMD_ROTATE   = 3'd5;

    localparam logic STATUS_DONE      = 1'b0;
    localparam logic STATUS_BAD_RANGE = 1'b1;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [FIELD_BITS-1:0] entry_index;
        logic [FIELD_BITS-1:0] last_index;
        logic [FIELD_BITS-1:0] red_in;
        logic [FIELD_BITS-1:0] green_in;
        logic [FIELD_BITS-1:0] blue_in;
        logic [FIELD_BITS-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] red_out;
        logic [FIELD_BITS-1:0] green_out;
        logic [FIELD_BITS-1:0] blue_out;
        logic                  status;
    } rsp_t;

    // Source of the data written into the working palette
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_INPUT,
        SRC_DIM,
        SRC_BRIGHT,
        SRC_RDATA,
        SRC_SAVED
    } wsrc_t;

    typedef struct packed {
        logic  load;       // capture request payload
        logic  rd_en;      // read both palettes at rd_addr
        logic  wp_we;      // write working palette at wr_addr
        logic  tp_we;      // write target palette at wr_addr
        wsrc_t wsrc;
        logic  save;       // keep the last working read for rotate
        logic  res_load;   // load the response register
        logic  res_read;   // response carries the read entry
        logic  res_status;
    } dp_ctrl_t;

endpackage

/* rtl/core/palette_fade_rotate_engine.sv */
// Top level of the palette fade and rotate engine: controller plus datapath.
// Depends on pfre_pkg, pfre_ctrl and pfre_datapath.
//
// The engine holds a working and a target palette of PALETTE_ENTRIES RGB
// entries and handles one request at a time. After reset it clears both
// palettes before req_ready rises. Write, read and unused commands go
// through ST_SINGLE to ST_FINISH; dim and brighten walk every entry, one
// entry a cycle; a valid rotate walks entry_index to last_index and then
// writes the saved first entry at last_index, and an invalid one goes
// straight to ST_FINISH with a bad-range status. A new request may be taken
// while the previous response is still waiting on rsp_ready.
module palette_fade_rotate_engine #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int CHANNEL_BITS    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pfre_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pfre_pkg::rsp_t rsp
);
    import pfre_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    dp_ctrl_t         ctrl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    pfre_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    pfre_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .CHANNEL_BITS    (CHANNEL_BITS)
    ) u_datapath (
        .clk     (clk),
        .req     (req),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rsp     (rsp)
    );

endmodule

/* rtl/core/pfre_datapath.sv */
// Datapath: working and target palette memories, per-channel dim/brighten
// arithmetic, rotate save register and response register. Uses pfre_pkg.
module pfre_datapath #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int CHANNEL_BITS    = 8
) (
    input  logic                                  clk,
    input  pfre_pkg::req_t                        req,
    input  pfre_pkg::dp_ctrl_t                    ctrl,
    input  logic [$clog2(PALETTE_ENTRIES)-1:0]    rd_addr,
    input  logic [$clog2(PALETTE_ENTRIES)-1:0]    wr_addr,
    output pfre_pkg::rsp_t                        rsp
);
    import pfre_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int EW    = 3 * CB;
    localparam int DW    = (CB > FIELD_BITS) ? CB : FIELD_BITS;
    localparam int SW    = DW + 1;

    logic [EW-1:0]         wp_mem [PALETTE_ENTRIES];
    logic [EW-1:0]         tp_mem [PALETTE_ENTRIES];
    logic [EW-1:0]         wp_rdata_reg;
    logic [EW-1:0]         tp_rdata_reg;
    logic [EW-1:0]         saved_reg;
    logic [EW-1:0]         in_rgb_reg;
    logic [FIELD_BITS-1:0] amount_reg;
    rsp_t                  rsp_reg;

    logic [EW-1:0]         dim_data;
    logic [EW-1:0]         bright_data;
    logic [EW-1:0]         wp_wdata;
    logic [EW-1:0]         tp_wdata;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [DW-1:0] vx;
            logic [DW-1:0] ax;
            logic [SW-1:0] s;
            logic [CB-1:0] t;
            vx = DW'(wp_rdata_reg[c*CB +: CB]);
            ax = DW'(amount_reg);
            t  = tp_rdata_reg[c*CB +: CB];
            s  = SW'(wp_rdata_reg[c*CB +: CB]) + SW'(amount_reg);
            // saturate at zero
            dim_data[c*CB +: CB]    = (vx > ax) ? CB'(vx - ax) : '0;
            // clamp at the target channel
            bright_data[c*CB +: CB] = (s > SW'(t)) ? t : CB'(s);
        end
    end

    always_comb
    begin
        case (ctrl.wsrc)
            SRC_INPUT:  wp_wdata = in_rgb_reg;
            SRC_DIM:    wp_wdata = dim_data;
            SRC_BRIGHT: wp_wdata = bright_data;
            SRC_RDATA:  wp_wdata = wp_rdata_reg;
            SRC_SAVED:  wp_wdata = saved_reg;
            default:    wp_wdata = '0;
        endcase
        tp_wdata = (ctrl.wsrc == SRC_INPUT) ? in_rgb_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wp_we)
        begin
            wp_mem[wr_addr] <= wp_wdata;
        end
        if (ctrl.tp_we)
        begin
            tp_mem[wr_addr] <= tp_wdata;
        end
        if (ctrl.rd_en)
        begin
            wp_rdata_reg <= wp_mem[rd_addr];
            tp_rdata_reg <= tp_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            in_rgb_reg <= {CB'(req.blue_in), CB'(req.green_in), CB'(req.red_in)};
            amount_reg <= req.amount;
        end
        if (ctrl.save)
        begin
            saved_reg <= wp_rdata_reg;
        end
        if (ctrl.res_load)
        begin
            if (ctrl.res_read)
            begin
                rsp_reg.red_out   <= FIELD_BITS'(wp_rdata_reg[0*CB +: CB]);
                rsp_reg.green_out <= FIELD_BITS'(wp_rdata_reg[1*CB +: CB]);
                rsp_reg.blue_out  <= FIELD_BITS'(wp_rdata_reg[2*CB +: CB]);
            end
            else
            begin
                rsp_reg.red_out   <= '0;
                rsp_reg.green_out <= '0;
                rsp_reg.blue_out  <= '0;
            end
            rsp_reg.status <= ctrl.res_status;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* rtl/core/pfre_ctrl.sv */
// Controller: sequences clearing, single writes and reads, palette walks for
// dim, brighten and rotate, and the response handshake. Uses pfre_pkg.
module pfre_ctrl #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  pfre_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output pfre_pkg::dp_ctrl_t                    ctrl,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]    rd_addr,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]    wr_addr
);
    import pfre_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > FIELD_BITS) ? CNT_W : FIELD_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SINGLE,
        ST_WALK,
        ST_ROT_LAST,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [2:0]       cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_reg;
    logic             ok_reg;
    logic             status_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] end_reg;
    logic             first_pend_reg;
    logic             wb_pend_reg;
    logic             wb_save_reg;
    logic [IDX_W-1:0] wb_addr_reg;
    logic             rsp_valid_reg;

    logic idx_ok;
    logic rot_ok;
    logic is_rot;
    logic walk_rd;

    assign idx_ok = CMP_W'(req.entry_index) < CMP_W'(PALETTE_ENTRIES);
    assign rot_ok = (req.entry_index < req.last_index)
                 && (CMP_W'(req.last_index) < CMP_W'(PALETTE_ENTRIES));
    assign is_rot  = (cmd_reg == CMD_ROTATE);
    assign walk_rd = (rd_cnt_reg < end_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctrl    = '0;
        rd_addr = rd_cnt_reg[IDX_W-1:0];
        wr_addr = wb_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.wp_we = 1'b1;
                ctrl.tp_we = 1'b1;
                ctrl.wsrc  = SRC_ZERO;
                wr_addr    = rd_cnt_reg[IDX_W-1:0];
            end
            ST_IDLE:
            begin
                ctrl.load = req_valid;
            end
            ST_SINGLE:
            begin
                rd_addr = idx_reg;
                wr_addr = idx_reg;
                if (ok_reg)
                begin
                    unique case (cmd_reg)
                        CMD_WR_WORK:
                        begin
                            ctrl.wp_we = 1'b1;
                            ctrl.wsrc  = SRC_INPUT;
                        end
                        CMD_WR_TGT:
                        begin
                            ctrl.tp_we = 1'b1;
                            ctrl.wsrc  = SRC_INPUT;
                        end
                        CMD_RD_WORK:
                        begin
                            ctrl.rd_en = 1'b1;
                        end
                        default:
                        begin
                            ctrl.rd_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                ctrl.rd_en = walk_rd;
                ctrl.wp_we = wb_pend_reg && !wb_save_reg;
                ctrl.save  = wb_pend_reg && wb_save_reg;
                unique case (cmd_reg)
                    CMD_DIM:      ctrl.wsrc = SRC_DIM;
                    CMD_BRIGHTEN: ctrl.wsrc = SRC_BRIGHT;
                    default:      ctrl.wsrc = SRC_RDATA;
                endcase
            end
            ST_ROT_LAST:
            begin
                ctrl.wp_we = 1'b1;
                ctrl.wsrc  = SRC_SAVED;
                wr_addr    = last_reg;
            end
            ST_FINISH:
            begin
                ctrl.res_load   = !rsp_valid_reg || rsp_ready;
                ctrl.res_read   = (cmd_reg == CMD_RD_WORK) && ok_reg;
                ctrl.res_status = status_reg;
            end
            default:
            begin
                ctrl.wsrc = SRC_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cmd_reg        <= '0;
            idx_reg        <= '0;
            last_reg       <= '0;
            ok_reg         <= 1'b0;
            status_reg     <= STATUS_DONE;
            rd_cnt_reg     <= '0;
            end_reg        <= '0;
            first_pend_reg <= 1'b0;
            wb_pend_reg    <= 1'b0;
            wb_save_reg    <= 1'b0;
            wb_addr_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    if (rd_cnt_reg == CNT_W'(PALETTE_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg        <= req.cmd;
                        idx_reg        <= IDX_W'(req.entry_index);
                        last_reg       <= IDX_W'(req.last_index);
                        ok_reg         <= idx_ok;
                        status_reg     <= ((req.cmd == CMD_ROTATE) && !rot_ok)
                                          ? STATUS_BAD_RANGE : STATUS_DONE;
                        first_pend_reg <= 1'b1;
                        wb_pend_reg    <= 1'b0;
                        unique case (req.cmd) inside
                            CMD_DIM, CMD_BRIGHTEN:
                            begin
                                rd_cnt_reg <= '0;
                                end_reg    <= CNT_W'(PALETTE_ENTRIES);
                                state_reg  <= ST_WALK;
                            end
                            CMD_ROTATE:
                            begin
                                rd_cnt_reg <= CNT_W'(req.entry_index);
                                end_reg    <= CNT_W'(req.last_index) + CNT_W'(1);
                                state_reg  <= rot_ok ? ST_WALK : ST_FINISH;
                            end
                            default:
                            begin
                                state_reg <= ST_SINGLE;
                            end
                        endcase
                    end
                end
                ST_SINGLE:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_WALK:
                begin
                    if (walk_rd)
                    begin
                        // rotate writes each entry one place below where it was read
                        rd_cnt_reg     <= rd_cnt_reg + CNT_W'(1);
                        wb_pend_reg    <= 1'b1;
                        wb_save_reg    <= first_pend_reg && is_rot;
                        first_pend_reg <= 1'b0;
                        wb_addr_reg    <= is_rot ? IDX_W'(rd_cnt_reg - CNT_W'(1))
                                                 : rd_cnt_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        wb_pend_reg <= 1'b0;
                        if (!wb_pend_reg)
                        begin
                            state_reg <= is_rot ? ST_ROT_LAST : ST_FINISH;
                        end
                    end
                end
                ST_ROT_LAST:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // never read and write the same working entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.rd_en && ctrl.wp_we) |-> (rd_addr != wr_addr))
        else $error("palette read and write collide on one entry");

    // a waiting response is never overwritten
    a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.res_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response register overwritten while pending");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while busy");

    // the saved rotate entry never goes to memory in the same cycle
    a_save_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.save |-> (!ctrl.wp_we && is_rot))
        else $error("rotate save overlaps a write-back");

    // a bad rotate range touches no memory
    a_bad_range_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && status_reg == STATUS_BAD_RANGE)
            |-> (!ctrl.wp_we && !ctrl.tp_we))
        else $error("memory written for an invalid rotate range");
`endif

endmodule

/* tb/palette_fade_rotate_engine_tb.sv */
// Self-checking testbench for palette_fade_rotate_engine: directed and random requests,
// checked against a scoreboard that keeps its own working and target palettes.
// Depends on pfre_pkg and the engine RTL.

import pfre_pkg::*;

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
} colour_t;

class palette_tracker;
    colour_t working[256];
    colour_t target[256];
    rsp_t    awaited_rsp[$];
    int      failures;

    function new();
        foreach (working[i])
        begin
            working[i] = '0;
            target[i]  = '0;
        end
        failures = 0;
    endfunction

    function logic [7:0] fade_down(logic [7:0] v, logic [7:0] amt);
        return (v > amt) ? v - amt : 8'd0;
    endfunction

    function logic [7:0] fade_up(logic [7:0] v, logic [7:0] amt, logic [7:0] t);
        logic [8:0] sum;
        sum = {1'b0, v} + {1'b0, amt};
        return (sum > {1'b0, t}) ? t : sum[7:0];
    endfunction

    // Apply an accepted request to the palettes and queue the reply it should give
    function void note_request(req_t rq);
        rsp_t    reply;
        colour_t held;
        int      i;
        reply = '0;
        reply.status = STATUS_DONE;
        case (rq.cmd)
            CMD_WR_WORK:
            begin
                working[rq.entry_index].red   = rq.red_in;
                working[rq.entry_index].green = rq.green_in;
                working[rq.entry_index].blue  = rq.blue_in;
            end
            CMD_WR_TGT:
            begin
                target[rq.entry_index].red   = rq.red_in;
                target[rq.entry_index].green = rq.green_in;
                target[rq.entry_index].blue  = rq.blue_in;
            end
            CMD_RD_WORK:
            begin
                reply.red_out   = working[rq.entry_index].red;
                reply.green_out = working[rq.entry_index].green;
                reply.blue_out  = working[rq.entry_index].blue;
            end
            CMD_DIM:
            begin
                foreach (working[e])
                begin
                    working[e].red   = fade_down(working[e].red, rq.amount);
                    working[e].green = fade_down(working[e].green, rq.amount);
                    working[e].blue  = fade_down(working[e].blue, rq.amount);
                end
            end
            CMD_BRIGHTEN:
            begin
                foreach (working[e])
                begin
                    working[e].red   = fade_up(working[e].red, rq.amount, target[e].red);
                    working[e].green = fade_up(working[e].green, rq.amount, target[e].green);
                    working[e].blue  = fade_up(working[e].blue, rq.amount, target[e].blue);
                end
            end
            CMD_ROTATE:
            begin
                if (rq.entry_index >= rq.last_index)
                begin
                    reply.status = STATUS_BAD_RANGE;
                end
                else
                begin
                    // shift the section down one place and wrap the first entry to the end
                    held = working[rq.entry_index];
                    for (i = rq.entry_index; i < rq.last_index; i++)
                        working[i] = working[i + 1];
                    working[rq.last_index] = held;
                end
            end
            default:
            begin
            end
        endcase
        awaited_rsp.push_back(reply);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        failures++;
    endtask

    task check_response(rsp_t got);
        rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            report_mismatch($sformatf("response %h with no request outstanding", got));
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.red_out !== want.red_out)
                report_mismatch($sformatf("red_out %h, want %h", got.red_out, want.red_out));
            if (got.green_out !== want.green_out)
                report_mismatch($sformatf("green_out %h, want %h",
                                          got.green_out, want.green_out));
            if (got.blue_out !== want.blue_out)
                report_mismatch($sformatf("blue_out %h, want %h", got.blue_out, want.blue_out));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
        end
    endtask
endclass

module palette_fade_rotate_engine_tb;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int RANDOM_REQUESTS = 725;
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int DRAIN_CYCLES    = 300;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic       steady_flow = 1'b0;
    logic [7:0] hot_base    = 8'd0;
    int         idle_cycles = 0;

    palette_tracker tracker = new();

    palette_fade_rotate_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ready <= steady_flow || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                tracker.note_request(req);
            if (rsp_valid && rsp_ready)
                tracker.check_response(rsp);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic req_t make_request(logic [2:0] c, logic [7:0] first, logic [7:0] last,
                                          logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] amt);
        req_t rq;
        rq.cmd         = c;
        rq.entry_index = first;
        rq.last_index  = last;
        rq.red_in      = r;
        rq.green_in    = g;
        rq.blue_in     = b;
        rq.amount      = amt;
        return rq;
    endfunction

    // Mostly entries in a small window, so reads and rotates meet written data
    function automatic logic [7:0] pick_entry();
        logic [7:0] e;
        if ($urandom_range(9) < 7)
            e = hot_base + 8'($urandom_range(15));
        else
            e = 8'($urandom);
        return e;
    endfunction

    function automatic req_t random_request();
        req_t rq;
        int   sel;
        int   span;
        rq.entry_index = pick_entry();
        rq.last_index  = 8'($urandom);
        rq.red_in      = 8'($urandom);
        rq.green_in    = 8'($urandom);
        rq.blue_in     = 8'($urandom);
        if ($urandom_range(3) == 0)
            rq.amount = 8'($urandom);
        else
            rq.amount = 8'($urandom_range(12));
        sel = $urandom_range(99);
        if (sel < 24)
            rq.cmd = CMD_WR_WORK;
        else if (sel < 44)
            rq.cmd = CMD_WR_TGT;
        else if (sel < 70)
            rq.cmd = CMD_RD_WORK;
        else if (sel < 77)
            rq.cmd = CMD_DIM;
        else if (sel < 85)
            rq.cmd = CMD_BRIGHTEN;
        else if (sel < 95)
        begin
            rq.cmd = CMD_ROTATE;
            // keep most rotates valid and short; the rest keep fully random bounds
            if ($urandom_range(4) != 0)
            begin
                if (rq.entry_index == 8'd255)
                    rq.entry_index = 8'd254;
                if ($urandom_range(9) == 0)
                begin
                    rq.last_index = 8'd255;
                end
                else
                begin
                    span = $urandom_range(15, 1);
                    if (span > 255 - rq.entry_index)
                        span = 255 - rq.entry_index;
                    rq.last_index = rq.entry_index + 8'(span);
                end
            end
        end
        else if (sel < 98)
            rq.cmd = CMD_SPARE_6;
        else
            rq.cmd = CMD_SPARE_7;
        return rq;
    endfunction

    task automatic send_request(input req_t item);
        while (!steady_flow && $urandom_range(99) < 22)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    initial
    begin
        int n;
        hot_base = 8'($urandom_range(240));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_request(make_request(CMD_WR_TGT, 0, 0, 255, 255, 255, 0));
        send_request(make_request(CMD_WR_TGT, 255, 0, 8'hAA, 8'h55, 8'hFF, 0));
        send_request(make_request(CMD_WR_TGT, 2, 0, 50, 200, 0, 0));
        send_request(make_request(CMD_WR_WORK, 0, 255, 255, 0, 128, 255));
        send_request(make_request(CMD_WR_WORK, 255, 0, 1, 254, 127, 0));
        send_request(make_request(CMD_WR_WORK, 1, 0, 10, 20, 30, 0));
        send_request(make_request(CMD_WR_WORK, 2, 0, 100, 100, 100, 0));
        send_request(make_request(CMD_RD_WORK, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 255, 255, 255, 255, 255, 255));
        send_request(make_request(CMD_DIM, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 0, 0, 0, 0, 0, 0));
        // small channels saturate at zero
        send_request(make_request(CMD_DIM, 0, 0, 0, 0, 0, 5));
        send_request(make_request(CMD_RD_WORK, 1, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 0, 0, 0, 0, 0, 0));
        // entry 2 sits above its target in two channels: zero step still clamps
        send_request(make_request(CMD_BRIGHTEN, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 2, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_BRIGHTEN, 0, 0, 0, 0, 0, 255));
        send_request(make_request(CMD_RD_WORK, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 255, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 1, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_ROTATE, 0, 255, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 255, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_RD_WORK, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_ROTATE, 3, 4, 0, 0, 0, 0));
        // malformed ranges: equal bounds and reversed bounds
        send_request(make_request(CMD_ROTATE, 7, 7, 0, 0, 0, 0));
        send_request(make_request(CMD_ROTATE, 200, 10, 0, 0, 0, 0));
        send_request(make_request(CMD_ROTATE, 255, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_SPARE_6, 255, 255, 255, 255, 255, 255));
        send_request(make_request(CMD_SPARE_7, 1, 2, 3, 4, 5, 6));

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // hold both sides busy through one long stretch
            steady_flow <= (n >= 300 && n < 420);
            send_request(random_request());
        end
        req_valid   <= 1'b0;
        steady_flow <= 1'b0;

        while (tracker.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.awaited_rsp.size() != 0)
            tracker.report_mismatch($sformatf("%0d responses never arrived",
                                              tracker.awaited_rsp.size()));
        if (tracker.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/pfre_pkg.sv
rtl/core/pfre_datapath.sv
rtl/core/pfre_ctrl.sv
rtl/core/palette_fade_rotate_engine.sv
tb/palette_fade_rotate_engine_tb.sv
